/* design/kfs_pkg.sv */
// ----------------------------------------------------------------------------
// kfs_pkg
// Shared types and constants for the gated scalar Kalman smoother.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kfs_pkg;

  localparam int SAMPLE_FRAC_BITS_DEF = 12;
  localparam int VAR_FRAC_BITS_DEF    = 16;

  localparam int SAMPLE_W = 24;
  localparam int VAR_W    = 32;
  localparam int TENTHS_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  // gain is unsigned Q1.16
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // divider widths and step counts
  localparam int DIV_REM_W = 33;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_GAIN = DIV_CNT_W'(GAIN_W);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_VAR  = DIV_CNT_W'(VAR_W);

  // configuration reset values
  localparam logic [31:0]        MEAS_NOISE_RST = 32'd13107;
  localparam logic [31:0]        PROC_NOISE_RST = 32'd655;
  localparam logic signed [23:0] GATE_LOW_RST   = -24'sd819200;
  localparam logic signed [23:0] GATE_HIGH_RST  = 24'sd1228800;
  localparam logic               SENSOR_EN_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAS_NOISE = 8'd0,
    REG_PROC_NOISE = 8'd1,
    REG_GATE_LOW   = 8'd2,
    REG_GATE_HIGH  = 8'd3,
    REG_SENSOR_EN  = 8'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        meas_noise;
    logic [31:0]        proc_noise;
    logic signed [23:0] gate_low;
    logic signed [23:0] gate_high;
    logic               sensor_en;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem_init;
    logic [31:0]          low_init;
    logic [DIV_REM_W-1:0] den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PC,
    ST_MUL,
    ST_GQ_GO,
    ST_GQ_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_DIFF,
    ST_APPLY,
    ST_OUT
  } state_t;

endpackage

/* design/kfs_cfg.sv */
// ----------------------------------------------------------------------------
// kfs_cfg
// Configuration register file: noise variances, gate limits, sensor enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [kfs_pkg::CFG_DATA_W-1:0]   wr_data,
  output kfs_pkg::cfg_t                    cfg
);

  kfs_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        kfs_pkg::REG_MEAS_NOISE: cfg_nxt.meas_noise = wr_data;
        kfs_pkg::REG_PROC_NOISE: cfg_nxt.proc_noise = wr_data;
        kfs_pkg::REG_GATE_LOW:   cfg_nxt.gate_low   = $signed(wr_data[23:0]);
        kfs_pkg::REG_GATE_HIGH:  cfg_nxt.gate_high  = $signed(wr_data[23:0]);
        kfs_pkg::REG_SENSOR_EN:  cfg_nxt.sensor_en  = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.meas_noise <= kfs_pkg::MEAS_NOISE_RST;
      cfg_r.proc_noise <= kfs_pkg::PROC_NOISE_RST;
      cfg_r.gate_low   <= kfs_pkg::GATE_LOW_RST;
      cfg_r.gate_high  <= kfs_pkg::GATE_HIGH_RST;
      cfg_r.sensor_en  <= kfs_pkg::SENSOR_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/kfs_div.sv */
// ----------------------------------------------------------------------------
// kfs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  kfs_pkg::div_req_t   req,
  output kfs_pkg::div_stat_t  stat
);

  localparam int RW = kfs_pkg::DIV_REM_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [RW-1:0]                 den_r, den_nxt;
  logic [31:0]                   low_r, low_nxt;
  logic [31:0]                   quot_r, quot_nxt;
  logic [kfs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RW:0]                   trial;
  logic [RW:0]                   trial_sub;
  logic                          fits;

  // remainder starts below the divisor, so it never needs more than RW bits
  assign trial     = {rem_r, low_r[31]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem_init;
      den_nxt  = req.den;
      low_nxt  = req.low_init;
      quot_nxt = '0;
      cnt_nxt  = req.steps;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial_sub[RW-1:0] : trial[RW-1:0];
      low_nxt  = {low_r[30:0], 1'b0};
      quot_nxt = {quot_r[30:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == kfs_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule

/* design/gated_scalar_kalman_smoother.sv */
// ----------------------------------------------------------------------------
// gated_scalar_kalman_smoother
// Gated scalar Kalman filter for one temperature sensor.
//
// One signed Q12.12 sample enters on the in_ channel (in_valid / in_stall).
// For every item one result leaves on the out_ channel: the accepted flag,
// the estimate rounded to tenths and the error variance in Q16.16.
// A sample that fails the gate or arrives while the sensor is disabled
// leaves the filter untouched; its result goes straight to the output state.
// An accepted sample runs one filter step on a small sequencer around a
// single serial divider, for the gain and then the variance (both skipped
// when the predicted variance is zero); the next item can be taken once
// its result is registered. The block takes no item while a step is in
// progress. A finished result sits in the output register; the block
// accepts the next item meanwhile, but holds its own result stage while
// out_stall keeps the old one waiting. Registers on the cfg_ channel are
// always ready; the user must write them only while idle, which the block
// itself does not enforce. Reset restores the register defaults, clears
// the primed flag, zeroes the estimate, sets the variance to 1.0 and drops out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gated_scalar_kalman_smoother #(
  parameter int SAMPLE_FRAC_BITS = kfs_pkg::SAMPLE_FRAC_BITS_DEF,
  parameter int VAR_FRAC_BITS    = kfs_pkg::VAR_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [kfs_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_accepted,
  output logic signed [kfs_pkg::TENTHS_W-1:0] out_estimate_tenths,
  output logic [kfs_pkg::VAR_W-1:0]           out_error_variance,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int GW = kfs_pkg::GAIN_W;
  localparam int TW = 29;
  localparam logic [31:0]   VarOne     = 32'd1 << VAR_FRAC_BITS;
  localparam logic [TW-1:0] TenthsHalf = TW'(1) << (SAMPLE_FRAC_BITS - 1);
  localparam logic [41:0]   GainHalf   = 42'd1 << (kfs_pkg::GAIN_BITS - 1);

  kfs_pkg::cfg_t      cfg;
  kfs_pkg::div_req_t  div_req;
  kfs_pkg::div_stat_t div_stat;
  kfs_pkg::state_t    state_r, state_nxt;

  logic              primed_r, primed_nxt;
  logic signed [23:0] est_r, est_nxt;
  logic [31:0]       var_r, var_nxt;
  logic signed [23:0] s_r, s_nxt;
  logic              acc_r, acc_nxt;
  logic [31:0]       pc_r, pc_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [32:0]       den_r, den_nxt;
  logic [GW-1:0]     gq_r, gq_nxt;
  logic [24:0]       mag_r, mag_nxt;
  logic              neg_r, neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic signed [15:0] out_tenths_r, out_tenths_nxt;
  logic [31:0]       out_var_r, out_var_nxt;

  logic              in_take;
  logic              gate_ok;
  logic [32:0]       pc_sum;
  logic [24:0]       diff;
  logic [41:0]       gain_prod;
  logic [25:0]       gain_q;
  logic [24:0]       est_ext;
  logic [24:0]       est_new;

  function automatic logic signed [15:0] to_tenths(input logic signed [23:0] x);
    logic [24:0]   xe;
    logic [24:0]   mag;
    logic [TW-1:0] scaled;
    logic [TW-1:0] q;
    logic signed [15:0] res;
    xe     = {x[23], x};
    mag    = x[23] ? (25'd0 - xe) : xe;
    scaled = (TW'(mag) << 3) + (TW'(mag) << 1);
    q      = (scaled + TenthsHalf) >> SAMPLE_FRAC_BITS;
    if (x[23]) begin
      res = (q > TW'(32768)) ? -16'sd32768 : $signed(16'd0 - q[15:0]);
    end else begin
      res = (q > TW'(32767)) ? 16'sd32767 : $signed(q[15:0]);
    end
    return res;
  endfunction

  kfs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != kfs_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign gate_ok   = cfg.sensor_en && (in_sample >= $signed(cfg.gate_low)) &&
                     (in_sample <= $signed(cfg.gate_high));

  assign pc_sum    = {1'b0, var_r} + {1'b0, cfg.proc_noise};
  assign diff      = {s_r[23], s_r} - {est_r[23], est_r};
  assign gain_prod = 42'(mag_r) * 42'(gq_r);
  assign gain_q    = 26'((gain_prod + GainHalf) >> kfs_pkg::GAIN_BITS);
  assign est_ext   = {est_r[23], est_r};
  assign est_new   = neg_r ? (est_ext - gain_q[24:0]) : (est_ext + gain_q[24:0]);

  always_comb begin
    state_nxt      = state_r;
    primed_nxt     = primed_r;
    est_nxt        = est_r;
    var_nxt        = var_r;
    s_nxt          = s_r;
    acc_nxt        = acc_r;
    pc_nxt         = pc_r;
    prod_nxt       = prod_r;
    den_nxt        = den_r;
    gq_nxt         = gq_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_acc_nxt    = out_acc_r;
    out_tenths_nxt = out_tenths_r;
    out_var_nxt    = out_var_r;
    div_req        = '0;

    case (state_r)
      kfs_pkg::ST_IDLE: begin
        if (in_take) begin
          s_nxt   = in_sample;
          acc_nxt = gate_ok;
          if (gate_ok) begin
            // first accepted item primes the filter
            if (!primed_r) begin
              primed_nxt = 1'b1;
              est_nxt    = in_sample;
              var_nxt    = VarOne;
            end
            state_nxt = kfs_pkg::ST_PC;
          end else begin
            state_nxt = kfs_pkg::ST_OUT;
          end
        end
      end
      kfs_pkg::ST_PC: begin
        pc_nxt    = pc_sum[32] ? '1 : pc_sum[31:0];
        state_nxt = kfs_pkg::ST_MUL;
      end
      kfs_pkg::ST_MUL: begin
        if (pc_r == '0) begin
          gq_nxt    = kfs_pkg::GAIN_ONE;
          var_nxt   = '0;
          state_nxt = kfs_pkg::ST_DIFF;
        end else begin
          prod_nxt  = 64'(pc_r) * 64'(cfg.meas_noise);
          den_nxt   = {1'b0, pc_r} + {1'b0, cfg.meas_noise};
          state_nxt = kfs_pkg::ST_GQ_GO;
        end
      end
      kfs_pkg::ST_GQ_GO: begin
        // gain = (pc << 16) / den; top part pc >> 1 is already below den
        div_req.start    = 1'b1;
        div_req.rem_init = {2'b00, pc_r[31:1]};
        div_req.low_init = {pc_r[0], 31'd0};
        div_req.den      = den_r;
        div_req.steps    = kfs_pkg::DIV_STEPS_GAIN;
        state_nxt        = kfs_pkg::ST_GQ_WAIT;
      end
      kfs_pkg::ST_GQ_WAIT: begin
        if (div_stat.done) begin
          gq_nxt    = div_stat.quot[GW-1:0];
          state_nxt = kfs_pkg::ST_VAR_GO;
        end
      end
      kfs_pkg::ST_VAR_GO: begin
        // variance = pc*r / den, quotient fits 32 bits since it is below r
        div_req.start    = 1'b1;
        div_req.rem_init = {1'b0, prod_r[63:32]};
        div_req.low_init = prod_r[31:0];
        div_req.den      = den_r;
        div_req.steps    = kfs_pkg::DIV_STEPS_VAR;
        state_nxt        = kfs_pkg::ST_VAR_WAIT;
      end
      kfs_pkg::ST_VAR_WAIT: begin
        if (div_stat.done) begin
          var_nxt   = div_stat.quot;
          state_nxt = kfs_pkg::ST_DIFF;
        end
      end
      kfs_pkg::ST_DIFF: begin
        neg_nxt   = diff[24];
        mag_nxt   = diff[24] ? (25'd0 - diff) : diff;
        state_nxt = kfs_pkg::ST_APPLY;
      end
      kfs_pkg::ST_APPLY: begin
        // gain never exceeds one, so the estimate stays within 24 bits
        est_nxt   = est_new[23:0];
        state_nxt = kfs_pkg::ST_OUT;
      end
      kfs_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_acc_nxt    = acc_r;
          out_tenths_nxt = to_tenths(est_r);
          out_var_nxt    = var_r;
          state_nxt      = kfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfs_pkg::ST_IDLE;
      primed_r    <= 1'b0;
      est_r       <= '0;
      var_r       <= VarOne;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s_r          <= s_nxt;
    acc_r        <= acc_nxt;
    pc_r         <= pc_nxt;
    prod_r       <= prod_nxt;
    den_r        <= den_nxt;
    gq_r         <= gq_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    out_acc_r    <= out_acc_nxt;
    out_tenths_r <= out_tenths_nxt;
    out_var_r    <= out_var_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_estimate_tenths = out_tenths_r;
  assign out_error_variance  = out_var_r;

`ifndef SYNTH
  a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kfs_pkg::ST_DIFF) |-> (gq_r <= kfs_pkg::GAIN_ONE))
    else $error("kalman gain above one");

  a_var_le_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kfs_pkg::ST_DIFF) |-> (var_r <= pc_r))
    else $error("updated variance above predicted variance");

  a_primed_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kfs_pkg::ST_OUT && acc_r) |-> primed_r)
    else $error("accepted item without primed filter");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !gate_ok) |=>
      (state_r == kfs_pkg::ST_OUT && $stable(est_r) && $stable(var_r)))
    else $error("rejected item changed filter state");
`endif

endmodule

/* verif/kfs_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfs_result_checker
// Watches the sample, result and register channels of the smoother. It keeps
// its own copy of the registers and the filter state, runs one fixed-point
// Kalman update per sample item and compares each result item in order.
// ----------------------------------------------------------------------------

module kfs_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [kfs_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_accepted,
  input  logic signed [kfs_pkg::TENTHS_W-1:0] out_estimate_tenths,
  input  logic [kfs_pkg::VAR_W-1:0]           out_error_variance,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  gated_in,
  output int                                  results_seen
);
  import kfs_pkg::*;

  typedef struct packed {
    logic                        accepted;
    logic signed [TENTHS_W-1:0]  tenths;
    logic [VAR_W-1:0]            variance;
  } filter_out_t;

  // register copy
  logic [31:0]                meas_noise;
  logic [31:0]                proc_noise;
  logic signed [SAMPLE_W-1:0] gate_lo;
  logic signed [SAMPLE_W-1:0] gate_hi;
  logic                       sensor_on;

  // filter state
  logic               primed;
  logic signed [31:0] est;
  logic [VAR_W-1:0]   var_p;

  filter_out_t estimate_q[$];

  function automatic logic signed [TENTHS_W-1:0] tenths_of(input logic signed [31:0] x);
    logic signed [63:0] xw;
    logic [63:0]        mag;
    logic [63:0]        q;
    xw  = x;
    mag = (xw < 0) ? -xw : xw;
    q   = (mag * 64'd10 + (64'd1 << (SAMPLE_FRAC_BITS_DEF - 1))) >> SAMPLE_FRAC_BITS_DEF;
    if (xw < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      return TENTHS_W'(-q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return TENTHS_W'(q);
  endfunction

  function automatic filter_out_t kalman_update(input logic signed [SAMPLE_W-1:0] s);
    logic               ok;
    logic [63:0]        pc;
    logic [63:0]        den;
    logic [63:0]        gain;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [63:0] diff;
    logic signed [63:0] delta;
    filter_out_t        res;
    ok = sensor_on && (s >= gate_lo) && (s <= gate_hi);
    if (ok) begin
      if (!primed) begin
        primed = 1'b1;
        est    = s;
        var_p  = VAR_W'(1) << VAR_FRAC_BITS_DEF;
      end
      pc = 64'(var_p) + 64'(proc_noise);
      if (pc > 64'hFFFF_FFFF) pc = 64'hFFFF_FFFF;
      if (pc == 64'd0) begin
        gain  = 64'd1 << GAIN_BITS;
        var_p = '0;
      end else begin
        den   = pc + 64'(meas_noise);
        gain  = (pc << GAIN_BITS) / den;
        var_p = VAR_W'((pc * 64'(meas_noise)) / den);
      end
      diff  = s - est;
      mag   = (diff < 0) ? -diff : diff;
      q     = (mag * gain + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
      delta = (diff < 0) ? -$signed(q) : $signed(q);
      est   = 32'(64'(est) + delta);
    end
    res.accepted = ok;
    res.tenths   = tenths_of(est);
    res.variance = var_p;
    return res;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    filter_out_t want;
    if (!rst_n) begin
      meas_noise   = MEAS_NOISE_RST;
      proc_noise   = PROC_NOISE_RST;
      gate_lo      = GATE_LOW_RST;
      gate_hi      = GATE_HIGH_RST;
      sensor_on    = SENSOR_EN_RST;
      primed       = 1'b0;
      est          = '0;
      var_p        = VAR_W'(1) << VAR_FRAC_BITS_DEF;
      fail_count   = 0;
      gated_in     = 0;
      results_seen = 0;
      estimate_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MEAS_NOISE: meas_noise = cfg_data;
          REG_PROC_NOISE: proc_noise = cfg_data;
          REG_GATE_LOW:   gate_lo    = cfg_data[SAMPLE_W-1:0];
          REG_GATE_HIGH:  gate_hi    = cfg_data[SAMPLE_W-1:0];
          REG_SENSOR_EN:  sensor_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (estimate_q.size() == 0) begin
          fail_count++;
          $display("%0t: result item with nothing expected, actual accepted %0d",
                   $time, out_accepted);
          $display("  tenths %0d variance %0d", out_estimate_tenths, out_error_variance);
        end else begin
          want = estimate_q.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("estimate_tenths", want.tenths, out_estimate_tenths);
          check_field("error_variance", want.variance, out_error_variance);
        end
      end
      if (in_valid && !in_stall) begin
        want = kalman_update(in_sample);
        if (want.accepted) gated_in++;
        estimate_q.push_back(want);
      end
    end
    pending = estimate_q.size();
  end

endmodule

/* verif/gated_scalar_kalman_smoother_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_scalar_kalman_smoother_tb
// Drives temperature samples and register settings into the smoother: a short
// directed part on gate edges, noise extremes and rounding, then random phases
// of slowly drifting readings mixed with out-of-gate and raw noise samples.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module gated_scalar_kalman_smoother_tb;
  import kfs_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 152;
  localparam int HOLD_PHASE       = 4;
  localparam int SETTLE_CYCLES    = 64;
  localparam int ONE_DEG          = 1 << SAMPLE_FRAC_BITS_DEF;
  localparam int SAMPLE_MIN       = -(1 << (SAMPLE_W - 1));
  localparam int SAMPLE_MAX       = (1 << (SAMPLE_W - 1)) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFF;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_accepted;
  logic signed [TENTHS_W-1:0]  out_estimate_tenths;
  logic [VAR_W-1:0]            out_error_variance;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int fail_count;
  int pending;
  int gated_in;
  int results_seen;

  logic idle_on = 1'b1;
  int   hold_requests = 0;
  int   cycle_cnt = 0;
  int   samples_sent = 0;
  int   reg_writes = 0;
  int   settings_used = 1;
  int   cur_lo = GATE_LOW_RST;
  int   cur_hi = GATE_HIGH_RST;
  int   level = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  gated_scalar_kalman_smoother u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_estimate_tenths (out_estimate_tenths),
    .out_error_variance  (out_error_variance),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  kfs_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_estimate_tenths (out_estimate_tenths),
    .out_error_variance  (out_error_variance),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending),
    .gated_in            (gated_in),
    .results_seen        (results_seen)
  );

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return 32'($urandom_range(1, 4 << VAR_FRAC_BITS_DEF));
      4:       return 32'($urandom);
      default: return 32'($urandom_range(0, 2000));
    endcase
  endfunction

  // drifting reading around a level, with edge hits and raw noise mixed in
  function automatic int next_sample();
    int lo;
    int hi;
    int s;
    lo = cur_lo;
    hi = cur_hi;
    if (lo > hi) begin
      lo = SAMPLE_MIN;
      hi = SAMPLE_MAX;
    end
    case ($urandom_range(0, 19))
      0:       s = lo;
      1:       s = hi;
      2:       s = lo - 1;
      3:       s = hi + 1;
      4, 5:    s = rand_between(SAMPLE_MIN, SAMPLE_MAX);
      6: begin
        level = rand_between(lo, hi);
        s = level;
      end
      default: begin
        level = clamp(level + rand_between(-2 * ONE_DEG, 2 * ONE_DEG), lo, hi);
        s = clamp(level + rand_between(-ONE_DEG / 2, ONE_DEG / 2), lo, hi);
      end
    endcase
    return clamp(s, SAMPLE_MIN, SAMPLE_MAX);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic program_regs(input logic [31:0] r, input logic [31:0] pn,
                              input int lo, input int hi, input logic en);
    write_reg(REG_MEAS_NOISE, r);
    write_reg(REG_PROC_NOISE, pn);
    write_reg(REG_GATE_LOW, {8'($urandom_range(0, 255)), 24'(lo)});
    write_reg(REG_GATE_HIGH, {8'($urandom_range(0, 255)), 24'(hi)});
    write_reg(REG_SENSOR_EN, {31'($urandom), en});
    // unmapped index must leave every register alone
    write_reg(CFG_IDX_SPARE, 32'($urandom));
    cfg_valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    level  = (lo <= hi) ? lo + (hi - lo) / 2 : 0;
    settings_used++;
  endtask

  task automatic push_sample(input int v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= SAMPLE_W'(v);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_side
    int holds_served;
    int hold_cnt;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int   lo;
    int   hi;
    int   a;
    int   b;
    logic en;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: gate edges, rejects before and after priming
    push_sample(300 * ONE_DEG + 1);
    push_sample(-200 * ONE_DEG - 1);
    push_sample(-200 * ONE_DEG);
    push_sample(300 * ONE_DEG);
    push_sample(0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(25 * ONE_DEG);
    drain();

    // zero noise: unit gain, variance collapses, then zero predicted variance
    program_regs(32'd0, 32'd0, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);
    push_sample(ONE_DEG / 4);   // exactly 2.5 tenths
    push_sample(-ONE_DEG / 4);
    push_sample(0);
    drain();

    // largest noise: predicted variance saturates
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    push_sample(ONE_DEG);
    push_sample(-ONE_DEG);
    push_sample(SAMPLE_MAX);
    drain();

    // sensor off
    program_regs(MEAS_NOISE_RST, PROC_NOISE_RST, GATE_LOW_RST, GATE_HIGH_RST, 1'b0);
    push_sample(0);
    push_sample(ONE_DEG);
    drain();

    // crossed gate limits
    program_regs(MEAS_NOISE_RST, PROC_NOISE_RST, ONE_DEG, -ONE_DEG, 1'b1);
    push_sample(0);
    push_sample(ONE_DEG);
    push_sample(-ONE_DEG);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      en = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 7))
        0: begin
          lo = SAMPLE_MIN;
          hi = SAMPLE_MAX;
        end
        1: begin
          a  = rand_between(GATE_LOW_RST, GATE_HIGH_RST);
          lo = a + 1;
          hi = rand_between(GATE_LOW_RST, a);
        end
        2: begin
          a  = rand_between(SAMPLE_MIN, SAMPLE_MAX);
          b  = rand_between(SAMPLE_MIN, SAMPLE_MAX);
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
        default: begin
          a  = rand_between(GATE_LOW_RST, GATE_HIGH_RST);
          b  = rand_between(GATE_LOW_RST, GATE_HIGH_RST);
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
      endcase
      program_regs(pick_noise(), pick_noise(), clamp(lo, SAMPLE_MIN, SAMPLE_MAX), hi, en);
      idle_on <= (p < RANDOM_PHASES - 3) && (p % 4 != 3);
      if (p == HOLD_PHASE) hold_requests <= hold_requests + 1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_sample(next_sample());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples (%0d through the gate) under %0d register settings",
             samples_sent, gated_in, settings_used);
    $display("%0d register writes, %0d result items compared", reg_writes, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
